// File: hdl/dr_pkg.sv
// Shared types, codes and rectangle helpers for the dirty rectangle tracker.
// No dependencies; used by dr_cell and dirty_rect_merge_tracker_core.
`default_nettype none

package dr_pkg;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] w;
        logic signed [15:0] h;
    } rect_t;

    // Per-cycle command broadcast to every cell of the list
    typedef struct packed {
        logic clear;   // zero the entry
        logic load;    // take load data if the cell index matches
        logic shift;   // take the upper neighbor if the cell index is at or above
    } ctl_t;

    typedef enum logic [1:0] {
        FUNC_MARK  = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_FULL  = 2'd2,
        FUNC_READ  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        CFG_BOUND_X = 2'd0,
        CFG_BOUND_Y = 2'd1,
        CFG_BOUND_W = 2'd2,
        CFG_BOUND_H = 2'd3
    } cfg_idx_t;

    localparam logic signed [17:0] SAT_MAX = 18'sd32767;

    function automatic logic signed [16:0] sx17(input logic signed [15:0] v);
        sx17 = {v[15], v};
    endfunction

    // Closed-edge test: shared edges count as touching
    function automatic logic rect_touch(input rect_t a, input rect_t b);
        logic signed [16:0] a_r;
        logic signed [16:0] a_b;
        logic signed [16:0] b_r;
        logic signed [16:0] b_b;
        a_r = sx17(a.x) + sx17(a.w);
        a_b = sx17(a.y) + sx17(a.h);
        b_r = sx17(b.x) + sx17(b.w);
        b_b = sx17(b.y) + sx17(b.h);
        rect_touch = (sx17(a.x) <= b_r) && (sx17(b.x) <= a_r) &&
                     (sx17(a.y) <= b_b) && (sx17(b.y) <= a_b);
    endfunction

    // Bounding union, width and height saturated to the 16-bit maximum
    function automatic rect_t rect_join(input rect_t a, input rect_t b);
        logic signed [16:0] a_r;
        logic signed [16:0] a_b;
        logic signed [16:0] b_r;
        logic signed [16:0] b_b;
        logic signed [16:0] rgt;
        logic signed [16:0] bot;
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [17:0] dw;
        logic signed [17:0] dh;
        rect_t r;
        a_r = sx17(a.x) + sx17(a.w);
        a_b = sx17(a.y) + sx17(a.h);
        b_r = sx17(b.x) + sx17(b.w);
        b_b = sx17(b.y) + sx17(b.h);
        rgt = (a_r > b_r) ? a_r : b_r;
        bot = (a_b > b_b) ? a_b : b_b;
        lx  = (a.x < b.x) ? a.x : b.x;
        ly  = (a.y < b.y) ? a.y : b.y;
        dw  = {rgt[16], rgt} - {{2{lx[15]}}, lx};
        dh  = {bot[16], bot} - {{2{ly[15]}}, ly};
        r.x = lx;
        r.y = ly;
        r.w = (dw > SAT_MAX) ? 16'sd32767 : dw[15:0];
        r.h = (dh > SAT_MAX) ? 16'sd32767 : dh[15:0];
        rect_join = r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/dr_cell.sv
// One list slot of the dirty rectangle tracker: holds an entry, shifts from
// its upper neighbor on removal and tests its entry against the probe.
// Depends on dr_pkg.
`default_nettype none

module dr_cell #(
    parameter int IW       = 4,
    parameter int CELL_IDX = 0
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire dr_pkg::ctl_t  ctl,
    input  wire logic [IW-1:0] sel_idx,
    input  wire dr_pkg::rect_t load_data,
    input  wire dr_pkg::rect_t nbr,
    input  wire dr_pkg::rect_t probe,
    output dr_pkg::rect_t      entry,
    output logic               touch
);

    localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

    dr_pkg::rect_t entry_reg;
    dr_pkg::rect_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.load && (sel_idx == MY_IDX))
        begin
            entry_next = load_data;
        end
        else if (ctl.clear)
        begin
            entry_next = '0;
        end
        else if (ctl.shift && (MY_IDX >= sel_idx))
        begin
            entry_next = nbr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;
    assign touch = dr_pkg::rect_touch(entry_reg, probe);

endmodule

`default_nettype wire

// File: hdl/dirty_rect_merge_tracker_core.sv
// Top level of the dirty rectangle tracker: sequencer plus a chain of list cells.
// Depends on dr_pkg and dr_cell.
`default_nettype none

// Command-style block: a beat is taken when start is high and busy is low, and
// exactly one result beat follows as a single-cycle done strobe that cannot be
// stalled, so the receiver must take it on that cycle. Clear, mark-full and read
// pass through the prepare and response states. A mark steps through clipping,
// finding the first stored entry touching the clipped rectangle, the merge loop
// (which absorbs one touching neighbor per pass and ends with a pass that finds
// none), and presenting the result. Each merge step tests every cell against the
// running union in parallel, picks the lowest touching cell, and removes it by
// shifting the upper cells down one slot.
// Bound registers are written over the cfg channel, which is always ready;
// write them only while the block is idle.
module dirty_rect_merge_tracker_core #(
    parameter int MAX_RECTS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         func,
    input  wire logic signed [15:0] rect_x,
    input  wire logic signed [15:0] rect_y,
    input  wire logic signed [15:0] rect_width,
    input  wire logic signed [15:0] rect_height,
    input  wire logic [3:0]         entry_index,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    output logic                    done,
    output logic signed [15:0]      entry_x,
    output logic signed [15:0]      entry_y,
    output logic signed [15:0]      entry_width,
    output logic signed [15:0]      entry_height,
    output logic [4:0]              dirty_count,
    output logic                    is_full
);

    localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CW = $clog2(MAX_RECTS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RECTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_MERGE,
        ST_RESP
    } state_t;

    state_t              state_reg;
    dr_pkg::func_t       func_reg;
    dr_pkg::rect_t       rect_reg;
    logic [3:0]          idx_reg;
    dr_pkg::rect_t       clip_reg;
    dr_pkg::rect_t       acc_reg;
    logic [IW-1:0]       s_reg;
    logic [CW-1:0]       count_reg;
    logic                full_reg;
    dr_pkg::rect_t       bound_reg;
    logic                done_reg;
    dr_pkg::rect_t       out_rect_reg;
    logic [4:0]          out_count_reg;
    logic                out_full_reg;

    // Cell chain wiring
    dr_pkg::rect_t       cell_entry [MAX_RECTS];
    dr_pkg::rect_t       cell_nbr   [MAX_RECTS];
    logic [MAX_RECTS-1:0] cell_touch;
    dr_pkg::ctl_t        ctl;
    logic [IW-1:0]       sel_idx;
    dr_pkg::rect_t       load_data;
    dr_pkg::rect_t       probe;

    // Combinational helpers
    logic                area_empty;
    logic signed [16:0]  clip_r;
    logic signed [16:0]  clip_b;
    logic signed [16:0]  bnd_r;
    logic signed [16:0]  bnd_b;
    logic signed [16:0]  rr;
    logic signed [16:0]  rb;
    logic signed [15:0]  cx;
    logic signed [15:0]  cy;
    logic signed [17:0]  cw;
    logic signed [17:0]  ch;
    dr_pkg::rect_t       clip;
    logic                clip_empty;
    logic [MAX_RECTS-1:0] hit;
    logic                found;
    logic [IW-1:0]       first_idx;
    dr_pkg::rect_t       first_rect;
    logic                read_ok;
    dr_pkg::rect_t       read_rect;
    dr_pkg::rect_t       bound_rect;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    assign bound_rect = bound_reg;
    assign area_empty = (bound_reg.w <= 16'sd0) || (bound_reg.h <= 16'sd0);

    // Clip the requested rectangle to the bounds
    always_comb
    begin
        bnd_r  = dr_pkg::sx17(bound_reg.x) + dr_pkg::sx17(bound_reg.w);
        bnd_b  = dr_pkg::sx17(bound_reg.y) + dr_pkg::sx17(bound_reg.h);
        rr     = dr_pkg::sx17(rect_reg.x) + dr_pkg::sx17(rect_reg.w);
        rb     = dr_pkg::sx17(rect_reg.y) + dr_pkg::sx17(rect_reg.h);
        cx     = (rect_reg.x > bound_reg.x) ? rect_reg.x : bound_reg.x;
        cy     = (rect_reg.y > bound_reg.y) ? rect_reg.y : bound_reg.y;
        clip_r = (rr < bnd_r) ? rr : bnd_r;
        clip_b = (rb < bnd_b) ? rb : bnd_b;
        cw     = {clip_r[16], clip_r} - {{2{cx[15]}}, cx};
        ch     = {clip_b[16], clip_b} - {{2{cy[15]}}, cy};
        clip_empty = (cw <= 18'sd0) || (ch <= 18'sd0);
        clip.x = cx;
        clip.y = cy;
        clip.w = cw[15:0];
        clip.h = ch[15:0];
    end

    // Probe the chain with the clipped rectangle first, then the running union
    assign probe = (state_reg == ST_SCAN) ? clip_reg : acc_reg;

    // Lowest live cell touching the probe; the union's own slot is skipped
    always_comb
    begin
        for (int k = 0; k < MAX_RECTS; k++)
        begin
            hit[k] = cell_touch[k] && (CW'(k) < count_reg) &&
                     !((state_reg == ST_MERGE) && (IW'(k) == s_reg));
        end
        found     = |hit;
        first_idx = '0;
        for (int k = MAX_RECTS - 1; k >= 0; k--)
        begin
            if (hit[k])
            begin
                first_idx = IW'(k);
            end
        end
        first_rect = cell_entry[first_idx];
    end

    // Read port: entries at or past the count read as zero
    always_comb
    begin
        read_ok   = ({28'd0, idx_reg} < 32'(count_reg)) &&
                    ({28'd0, idx_reg} < 32'(MAX_RECTS));
        read_rect = read_ok ? cell_entry[IW'(idx_reg)] : '0;
    end

    // Cell commands
    always_comb
    begin
        ctl       = '0;
        sel_idx   = '0;
        load_data = '0;
        case (state_reg)
            ST_PREP:
            begin
                if (func_reg == dr_pkg::FUNC_CLEAR)
                begin
                    ctl.clear = 1'b1;
                end
                else if ((func_reg == dr_pkg::FUNC_FULL) && !area_empty)
                begin
                    ctl.clear = 1'b1;
                    ctl.load  = 1'b1;
                    load_data = bound_rect;
                end
            end
            ST_SCAN:
            begin
                if (!found)
                begin
                    if (count_reg >= MAX_CNT)
                    begin
                        // Collapse to one full-bounds entry
                        ctl.clear = 1'b1;
                        ctl.load  = 1'b1;
                        load_data = bound_rect;
                    end
                    else
                    begin
                        ctl.load  = 1'b1;
                        sel_idx   = IW'(count_reg);
                        load_data = clip_reg;
                    end
                end
            end
            ST_MERGE:
            begin
                if (found)
                begin
                    // Drop the absorbed entry: upper cells move down one slot
                    ctl.shift = 1'b1;
                    sel_idx   = first_idx;
                end
                else
                begin
                    ctl.load  = 1'b1;
                    sel_idx   = s_reg;
                    load_data = acc_reg;
                end
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < MAX_RECTS; g++)
        begin : g_cell
            if (g == MAX_RECTS - 1)
            begin : g_top
                assign cell_nbr[g] = '0;
            end
            else
            begin : g_mid
                assign cell_nbr[g] = cell_entry[g+1];
            end

            dr_cell #(
                .IW       (IW),
                .CELL_IDX (g)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .sel_idx   (sel_idx),
                .load_data (load_data),
                .nbr       (cell_nbr[g]),
                .probe     (probe),
                .entry     (cell_entry[g]),
                .touch     (cell_touch[g])
            );
        end
    endgenerate

    // Sequencer, list count, flags, bounds and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            full_reg      <= 1'b0;
            bound_reg     <= '0;
            done_reg      <= 1'b0;
            func_reg      <= dr_pkg::FUNC_MARK;
            rect_reg      <= '0;
            idx_reg       <= '0;
            clip_reg      <= '0;
            acc_reg       <= '0;
            s_reg         <= '0;
            out_rect_reg  <= '0;
            out_count_reg <= '0;
            out_full_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                case (dr_pkg::cfg_idx_t'(cfg_index))
                    dr_pkg::CFG_BOUND_X: bound_reg.x <= cfg_data;
                    dr_pkg::CFG_BOUND_Y: bound_reg.y <= cfg_data;
                    dr_pkg::CFG_BOUND_W: bound_reg.w <= cfg_data;
                    dr_pkg::CFG_BOUND_H: bound_reg.h <= cfg_data;
                    default:             bound_reg   <= bound_reg;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        func_reg  <= dr_pkg::func_t'(func);
                        rect_reg  <= {rect_x, rect_y, rect_width, rect_height};
                        idx_reg   <= entry_index;
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    state_reg <= ST_RESP;
                    case (func_reg)
                        dr_pkg::FUNC_MARK:
                        begin
                            if (!full_reg && !area_empty && !clip_empty)
                            begin
                                clip_reg  <= clip;
                                state_reg <= ST_SCAN;
                            end
                        end
                        dr_pkg::FUNC_CLEAR:
                        begin
                            count_reg <= '0;
                            full_reg  <= 1'b0;
                        end
                        dr_pkg::FUNC_FULL:
                        begin
                            if (!area_empty)
                            begin
                                count_reg <= CW'(1);
                                full_reg  <= 1'b1;
                            end
                        end
                        default:
                        begin
                            state_reg <= ST_RESP;
                        end
                    endcase
                end
                ST_SCAN:
                begin
                    if (found)
                    begin
                        acc_reg   <= dr_pkg::rect_join(first_rect, clip_reg);
                        s_reg     <= first_idx;
                        state_reg <= ST_MERGE;
                    end
                    else if (count_reg >= MAX_CNT)
                    begin
                        count_reg <= CW'(1);
                        full_reg  <= 1'b1;
                        state_reg <= ST_RESP;
                    end
                    else
                    begin
                        count_reg <= count_reg + CW'(1);
                        state_reg <= ST_RESP;
                    end
                end
                ST_MERGE:
                begin
                    if (found)
                    begin
                        // Absorb, remove, and restart the scan from the bottom
                        acc_reg   <= dr_pkg::rect_join(acc_reg, first_rect);
                        count_reg <= count_reg - CW'(1);
                        if (first_idx < s_reg)
                        begin
                            s_reg <= s_reg - IW'(1);
                        end
                    end
                    else
                    begin
                        state_reg <= ST_RESP;
                    end
                end
                ST_RESP:
                begin
                    done_reg      <= 1'b1;
                    out_rect_reg  <= (func_reg == dr_pkg::FUNC_READ) ? read_rect : '0;
                    out_count_reg <= 5'(count_reg);
                    out_full_reg  <= full_reg;
                    state_reg     <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done         = done_reg;
    assign entry_x      = out_rect_reg.x;
    assign entry_y      = out_rect_reg.y;
    assign entry_width  = out_rect_reg.w;
    assign entry_height = out_rect_reg.h;
    assign dirty_count  = out_count_reg;
    assign is_full      = out_full_reg;

    // The list never holds more entries than it has cells
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("list count above capacity");

    // Full state always means exactly one full-bounds entry
    a_full_single: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> (count_reg == CW'(1)))
        else $error("full flag with count other than one");

    // Every operation ends with its result beat
    a_done_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("operation finished without a result beat");

    // A result beat never overlaps a running operation
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

endmodule

`default_nettype wire
